### rtl/aad_pkg.sv
`default_nettype none
package aad_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CHAN_W     = 16;
  localparam int POS_W      = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0] in_ch0;
    logic [CHAN_W-1:0] in_ch1;
    logic [CHAN_W-1:0] in_ch2;
    logic [CHAN_W-1:0] in_ch3;
  } pix_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  out_col;
    logic [POS_W-1:0]  out_row;
    logic [CHAN_W-1:0] out_ch0;
    logic [CHAN_W-1:0] out_ch1;
    logic [CHAN_W-1:0] out_ch2;
    logic [CHAN_W-1:0] out_ch3;
    logic              frame_end;
  } pix_out_t;

  typedef struct packed {
    logic wr;
    logic first;
    logic capture;
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage
`default_nettype wire

### rtl/aad_ram.sv
`default_nettype none
module aad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/aad_axis.sv
`default_nettype none
module aad_axis #(
  parameter int MAX_DIM = 4096,
  localparam int IDX_W = $clog2(MAX_DIM),
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int UW    = $clog2(2 * MAX_DIM + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             init,
  input  logic             step,
  input  logic [DIM_W-1:0] size,
  input  logic [DIM_W-1:0] dst,
  output logic [IDX_W-1:0] hi,
  output logic             two,
  output logic             first,
  output logic             emit,
  output logic             emit_prev,
  output logic [DIM_W-1:0] span,
  output logic             wrap
);

  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] st;
  logic [IDX_W-1:0] stp;
  logic [UW-1:0]    u;
  logic [UW-1:0]    u_next;
  logic             last_hi;

  // u = (pos+1)*dst - hi*size, kept in (0, size]
  always_comb begin
    last_hi   = (u == UW'(size));
    two       = (u < UW'(dst));
    first     = (u <= UW'(dst));
    emit      = last_hi || two;
    emit_prev = !last_hi;
    span      = last_hi ? (DIM_W'(pos) - DIM_W'(st) + DIM_W'(1))
                        : (DIM_W'(pos) - DIM_W'(stp) + DIM_W'(1));
    wrap      = (DIM_W'(pos) + DIM_W'(1) == size);
    u_next    = u + UW'(dst);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hi  <= '0;
      st  <= '0;
      stp <= '0;
      u   <= '0;
    end else if (init || (step && wrap)) begin
      pos <= '0;
      hi  <= '0;
      st  <= '0;
      u   <= UW'(dst);
    end else if (step) begin
      pos <= pos + IDX_W'(1);
      if (u_next > UW'(size)) begin
        hi  <= hi + IDX_W'(1);
        u   <= u_next - UW'(size);
        stp <= st;
        st  <= pos + IDX_W'(1);
      end else begin
        u <= u_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/aad_lane.sv
`default_nettype none
module aad_lane #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int A_W   = $clog2(2 * MAX_DIM),
  localparam int N_W   = $clog2(MAX_DIM * MAX_DIM + 1),
  localparam int SUM_W = PIXEL_BITS + N_W,
  localparam int R_W   = SUM_W + 1,
  localparam int D_W   = N_W + PIXEL_BITS - 1
) (
  input  logic                    clk,
  input  aad_pkg::lane_ctrl_t     ctrl,
  input  logic [PIXEL_BITS-1:0]   pix,
  input  logic [A_W-1:0]          rd_addr,
  input  logic [A_W-1:0]          wr_addr,
  input  logic [N_W-1:0]          count,
  output logic [PIXEL_BITS-1:0]   avg
);

  logic [SUM_W-1:0]      rd_data;
  logic [SUM_W-1:0]      sum_new;
  logic [SUM_W-1:0]      sum_cap;
  logic [R_W-1:0]        rem;
  logic [D_W-1:0]        dvs;
  logic [PIXEL_BITS-1:0] q;

  assign sum_new = (ctrl.first ? '0 : rd_data) + SUM_W'(pix);
  assign avg     = q;

  aad_ram #(
    .WIDTH (SUM_W),
    .DEPTH (2 * MAX_DIM)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.wr),
    .wr_addr (wr_addr),
    .wr_data (sum_new),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr && ctrl.capture) begin
      sum_cap <= sum_new;
    end
    if (ctrl.load) begin
      rem <= R_W'(sum_cap) + R_W'(count >> 1);
      dvs <= D_W'(count) << (PIXEL_BITS - 1);
      q   <= '0;
    end else if (ctrl.step) begin
      if (rem >= R_W'(dvs)) begin
        rem <= rem - R_W'(dvs);
        q   <= {q[PIXEL_BITS-2:0], 1'b1};
      end else begin
        q <= {q[PIXEL_BITS-2:0], 1'b0};
      end
      dvs <= dvs >> 1;
    end
  end

endmodule
`default_nettype wire

### rtl/area_average_downscaler.sv
`default_nettype none
// channel   valid      stall      payload
// src       src_valid  src_stall  src_data (aad_pkg::pix_in_t)
// dst       dst_valid  dst_stall  dst_data (aad_pkg::pix_out_t)
// cfg       cfg_we     -          cfg_index, cfg_data
//
// every pixel is accepted, then up to four sum entries go through one
// read-modify-write port per channel lane, one entry a cycle, plus a write-back step
// a pixel that closes a footprint then passes ST_LOAD, ST_DIV and ST_HOLD for the divider
// reset and writes to known registers restart the trackers; sum memory is not cleared
// a held result does not block the next pixel unless that pixel closes a footprint too
module area_average_downscaler #(
  parameter int MAX_DIM      = 4096,
  parameter int PIXEL_BITS   = 16,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  aad_pkg::pix_in_t                    src_data,
  output logic                                dst_valid,
  input  logic                                dst_stall,
  output aad_pkg::pix_out_t                   dst_data,
  input  logic                                cfg_we,
  input  logic [aad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aad_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int SZ_W  = (DIM_W > aad_pkg::CFG_DATA_W) ? DIM_W : aad_pkg::CFG_DATA_W;
  localparam int A_W   = $clog2(2 * MAX_DIM);
  localparam int N_W   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DC_W  = $clog2(PIXEL_BITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RMW  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [aad_pkg::CFG_DATA_W-1:0] src_cols, src_rows, dst_cols, dst_rows;
  logic [2:0]                     chan_count;
  logic                           restart;

  logic [SZ_W-1:0]  sw_f, sh_f, dw_f, dh_f, scx, srx, dcx, drx;
  logic [DIM_W-1:0] sw, sh, dw, dh;
  logic [2:0]       nch;

  always_comb begin
    scx  = SZ_W'(src_cols);
    srx  = SZ_W'(src_rows);
    dcx  = SZ_W'(dst_cols);
    drx  = SZ_W'(dst_rows);
    sw_f = (scx == '0) ? SZ_W'(1) : ((scx > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : scx);
    sh_f = (srx == '0) ? SZ_W'(1) : ((srx > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : srx);
    dw_f = (dcx == '0) ? SZ_W'(1) : ((dcx > sw_f) ? sw_f : dcx);
    dh_f = (drx == '0) ? SZ_W'(1) : ((drx > sh_f) ? sh_f : drx);
    sw   = DIM_W'(sw_f);
    sh   = DIM_W'(sh_f);
    dw   = DIM_W'(dw_f);
    dh   = DIM_W'(dh_f);
    nch  = (chan_count == 3'd0) ? 3'd1
         : ((chan_count > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chan_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols   <= 13'd256;
      src_rows   <= 13'd256;
      dst_cols   <= 13'd128;
      dst_rows   <= 13'd128;
      chan_count <= 3'd4;
      restart    <= 1'b1;
    end else begin
      restart <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          aad_pkg::CFG_SRC_COLS: begin
            src_cols <= cfg_data;
            restart  <= 1'b1;
          end
          aad_pkg::CFG_SRC_ROWS: begin
            src_rows <= cfg_data;
            restart  <= 1'b1;
          end
          aad_pkg::CFG_DST_COLS: begin
            dst_cols <= cfg_data;
            restart  <= 1'b1;
          end
          aad_pkg::CFG_DST_ROWS: begin
            dst_rows <= cfg_data;
            restart  <= 1'b1;
          end
          aad_pkg::CFG_CHAN_COUNT: begin
            chan_count <= cfg_data[2:0];
            restart    <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  logic [2:0] state;
  logic       accept;

  assign src_stall = restart || (state != ST_IDLE);
  assign accept    = src_valid && !src_stall;

  // position trackers
  logic [IDX_W-1:0] c_hi, r_hi;
  logic             c_two, c_first, c_emit, c_eprev, c_wrap;
  logic             r_two, r_first, r_emit, r_eprev, r_wrap;
  logic [DIM_W-1:0] c_span, r_span;

  aad_axis #(.MAX_DIM (MAX_DIM)) u_col (
    .clk       (clk),
    .rst       (rst),
    .init      (restart),
    .step      (accept),
    .size      (sw),
    .dst       (dw),
    .hi        (c_hi),
    .two       (c_two),
    .first     (c_first),
    .emit      (c_emit),
    .emit_prev (c_eprev),
    .span      (c_span),
    .wrap      (c_wrap)
  );

  aad_axis #(.MAX_DIM (MAX_DIM)) u_row (
    .clk       (clk),
    .rst       (rst),
    .init      (restart),
    .step      (accept && c_wrap),
    .size      (sh),
    .dst       (dh),
    .hi        (r_hi),
    .two       (r_two),
    .first     (r_first),
    .emit      (r_emit),
    .emit_prev (r_eprev),
    .span      (r_span),
    .wrap      (r_wrap)
  );

  // per pixel latches
  logic [IDX_W-1:0]      ch_q, rh_q;
  logic                  ctwo_q, rtwo_q, first_q, emit_q, ceprev_q, reprev_q;
  logic [DIM_W-1:0]      cspan_q, rspan_q;
  logic [N_W-1:0]        n_q;

  logic [2:0]            idx;
  logic [DC_W-1:0]       dcnt;
  logic [A_W-1:0]        rd_addr;
  logic [A_W-1:0]        wr_addr_q;
  logic                  wr_q, wfirst_q, wcap_q;
  logic                  pvalid, pfirst, pcap;
  logic [IDX_W-1:0]      p_dc, p_dr;
  logic [IDX_W-1:0]      e_dc, e_dr;

  always_comb begin
    p_dc    = idx[0] ? (ch_q - IDX_W'(1)) : ch_q;
    p_dr    = idx[1] ? (rh_q - IDX_W'(1)) : rh_q;
    rd_addr = p_dr[0] ? (A_W'(MAX_DIM) + A_W'(p_dc)) : A_W'(p_dc);
    pvalid  = (state == ST_RMW) && !idx[2] && (!idx[1] || rtwo_q) && (!idx[0] || ctwo_q);
    pfirst  = (idx[1:0] == 2'd0) && first_q;
    pcap    = emit_q && (idx[1] == reprev_q) && (idx[0] == ceprev_q);
    e_dc    = ceprev_q ? (ch_q - IDX_W'(1)) : ch_q;
    e_dr    = reprev_q ? (rh_q - IDX_W'(1)) : rh_q;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q     <= c_hi;
      rh_q     <= r_hi;
      ctwo_q   <= c_two;
      rtwo_q   <= r_two;
      first_q  <= c_first && r_first;
      emit_q   <= c_emit && r_emit;
      ceprev_q <= c_eprev;
      reprev_q <= r_eprev;
      cspan_q  <= c_span;
      rspan_q  <= r_span;
    end
    n_q       <= N_W'(cspan_q) * N_W'(rspan_q);
    wr_addr_q <= rd_addr;
    wfirst_q  <= pfirst;
    wcap_q    <= pcap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      dcnt  <= '0;
      wr_q  <= 1'b0;
    end else begin
      wr_q <= pvalid;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RMW;
            idx   <= '0;
          end
        end
        ST_RMW: begin
          idx <= idx + 3'd1;
          if (idx[2]) begin
            state <= emit_q ? ST_LOAD : ST_IDLE;
          end
        end
        ST_LOAD: begin
          state <= ST_DIV;
          dcnt  <= '0;
        end
        ST_DIV: begin
          dcnt <= dcnt + DC_W'(1);
          if (dcnt == DC_W'(PIXEL_BITS - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!dst_valid || !dst_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // channel lanes
  aad_pkg::lane_ctrl_t   lctrl;
  logic [PIXEL_BITS-1:0] pix_in  [MAX_CHANNELS];
  logic [PIXEL_BITS-1:0] pix_q   [MAX_CHANNELS];
  logic [PIXEL_BITS-1:0] avg     [MAX_CHANNELS];
  logic [aad_pkg::CHAN_W-1:0] ch_out [4];

  always_comb begin
    lctrl.wr      = wr_q;
    lctrl.first   = wfirst_q;
    lctrl.capture = wcap_q;
    lctrl.load    = (state == ST_LOAD);
    lctrl.step    = (state == ST_DIV);
  end

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
    if (l == 0) begin : g_c0
      assign pix_in[l] = PIXEL_BITS'(src_data.in_ch0);
    end else if (l == 1) begin : g_c1
      assign pix_in[l] = PIXEL_BITS'(src_data.in_ch1);
    end else if (l == 2) begin : g_c2
      assign pix_in[l] = PIXEL_BITS'(src_data.in_ch2);
    end else begin : g_c3
      assign pix_in[l] = PIXEL_BITS'(src_data.in_ch3);
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        pix_q[l] <= pix_in[l];
      end
    end

    aad_lane #(
      .MAX_DIM    (MAX_DIM),
      .PIXEL_BITS (PIXEL_BITS)
    ) u_lane (
      .clk     (clk),
      .ctrl    (lctrl),
      .pix     (pix_q[l]),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr_q),
      .count   (n_q),
      .avg     (avg[l])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_out
    if (k < MAX_CHANNELS) begin : g_used
      assign ch_out[k] = (3'(k) < nch) ? aad_pkg::CHAN_W'(avg[k]) : '0;
    end else begin : g_none
      assign ch_out[k] = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (state == ST_HOLD && (!dst_valid || !dst_stall)) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && (!dst_valid || !dst_stall)) begin
      dst_data.out_col   <= aad_pkg::POS_W'(e_dc);
      dst_data.out_row   <= aad_pkg::POS_W'(e_dr);
      dst_data.out_ch0   <= ch_out[0];
      dst_data.out_ch1   <= ch_out[1];
      dst_data.out_ch2   <= ch_out[2];
      dst_data.out_ch3   <= ch_out[3];
      dst_data.frame_end <= (e_dc == IDX_W'(dw - DIM_W'(1)))
                         && (e_dr == IDX_W'(dh - DIM_W'(1)));
    end
  end

  logic unused_wrap;
  assign unused_wrap = r_wrap;

endmodule
`default_nettype wire

### test/aad_checker.sv
`timescale 1ns / 1ps
module aad_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_valid,
  input  logic                           src_stall,
  input  aad_pkg::pix_in_t               src_data,
  input  logic                           dst_valid,
  input  logic                           dst_stall,
  input  aad_pkg::pix_out_t              dst_data,
  input  logic                           cfg_we,
  input  logic [aad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aad_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             results_seen
);

  localparam int unsigned DIM = 4096;
  localparam int unsigned NCH = 4;

  logic [39:0] col_sums [0:2*DIM*NCH-1];
  int unsigned src_col, src_row;
  int unsigned reg_src_cols, reg_src_rows, reg_dst_cols, reg_dst_rows, reg_chans;
  aad_pkg::pix_out_t avg_q[$];

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned span_first(int unsigned d, int unsigned s, int unsigned n);
    return int'((longint'(d) * s) / n);
  endfunction

  function automatic int unsigned span_last(int unsigned d, int unsigned s, int unsigned n);
    longint unsigned e;
    e = (longint'(d + 1) * s + n - 1) / n;
    if (e > s) e = s;
    return int'(e) - 1;
  endfunction

  // destinations fed by source index c, highest first
  function automatic int covering(int unsigned c, int unsigned s, int unsigned n,
                                  output int unsigned lst [2]);
    int unsigned hi;
    hi = int'((longint'(c + 1) * n - 1) / s);
    if (hi > n - 1) hi = n - 1;
    lst[0] = hi;
    lst[1] = 0;
    if (hi > 0 && span_last(hi - 1, s, n) >= c) begin
      lst[1] = hi - 1;
      return 2;
    end
    return 1;
  endfunction

  task automatic average_pixel(aad_pkg::pix_in_t p);
    int unsigned sw, sh, dw, dh, nch, c, r, r0, r1, c0, c1, base;
    int unsigned cols [2];
    int unsigned rows [2];
    int nc, nr;
    logic [15:0] px [4];
    bit emitted, first;
    longint unsigned n, a;
    aad_pkg::pix_out_t e;
    sw = clampu(reg_src_cols, 1, DIM);
    sh = clampu(reg_src_rows, 1, DIM);
    dw = clampu(reg_dst_cols, 1, sw);
    dh = clampu(reg_dst_rows, 1, sh);
    nch = clampu(reg_chans, 1, NCH);
    c = src_col < sw ? src_col : sw - 1;
    r = src_row < sh ? src_row : sh - 1;
    px[0] = p.in_ch0; px[1] = p.in_ch1; px[2] = p.in_ch2; px[3] = p.in_ch3;
    nc = covering(c, sw, dw, cols);
    nr = covering(r, sh, dh, rows);
    emitted = 0;
    for (int i = 0; i < nr; i++) begin
      r0 = span_first(rows[i], sh, dh);
      r1 = span_last(rows[i], sh, dh);
      for (int j = 0; j < nc; j++) begin
        c0 = span_first(cols[j], sw, dw);
        c1 = span_last(cols[j], sw, dw);
        base = ((rows[i] % 2) * DIM + cols[j]) * NCH;
        first = (c == c0) && (r == r0);
        for (int k = 0; k < nch; k++)
          col_sums[base + k] = (first ? 40'd0 : col_sums[base + k]) + px[k];
        if (c == c1 && r == r1 && !emitted) begin
          n = longint'(c1 - c0 + 1) * (r1 - r0 + 1);
          e = '0;
          e.out_col = cols[j][aad_pkg::POS_W-1:0];
          e.out_row = rows[i][aad_pkg::POS_W-1:0];
          for (int k = 0; k < NCH; k++) begin
            a = (k < nch) ? (longint'(col_sums[base + k]) + n / 2) / n : 0;
            case (k)
              0: e.out_ch0 = a[15:0];
              1: e.out_ch1 = a[15:0];
              2: e.out_ch2 = a[15:0];
              default: e.out_ch3 = a[15:0];
            endcase
          end
          e.frame_end = (cols[j] == dw - 1) && (rows[i] == dh - 1);
          avg_q.push_back(e);
          emitted = 1;
        end
      end
    end
    if (c + 1 >= sw) begin
      src_col = 0;
      src_row = (r + 1 >= sh) ? 0 : r + 1;
    end else begin
      src_col = c + 1;
      src_row = r;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    aad_pkg::pix_out_t e;
    if (rst) begin
      reg_src_cols = 256; reg_src_rows = 256;
      reg_dst_cols = 128; reg_dst_rows = 128;
      reg_chans = 4;
      src_col = 0; src_row = 0;
      avg_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aad_pkg::CFG_SRC_COLS:   reg_src_cols = cfg_data;
          aad_pkg::CFG_SRC_ROWS:   reg_src_rows = cfg_data;
          aad_pkg::CFG_DST_COLS:   reg_dst_cols = cfg_data;
          aad_pkg::CFG_DST_ROWS:   reg_dst_rows = cfg_data;
          aad_pkg::CFG_CHAN_COUNT: reg_chans = cfg_data[2:0];
          default: ;
        endcase
        if (cfg_index <= aad_pkg::CFG_CHAN_COUNT) begin
          src_col = 0;
          src_row = 0;
        end
      end
      if (src_valid && !src_stall) average_pixel(src_data);
      if (dst_valid && !dst_stall) begin
        results_seen++;
        if (avg_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual %h", $time, dst_data);
          errors++;
        end else begin
          e = avg_q.pop_front();
          check_field("out_col", e.out_col, dst_data.out_col);
          check_field("out_row", e.out_row, dst_data.out_row);
          check_field("out_ch0", e.out_ch0, dst_data.out_ch0);
          check_field("out_ch1", e.out_ch1, dst_data.out_ch1);
          check_field("out_ch2", e.out_ch2, dst_data.out_ch2);
          check_field("out_ch3", e.out_ch3, dst_data.out_ch3);
          check_field("frame_end", e.frame_end, dst_data.frame_end);
        end
      end
    end
    pending = avg_q.size();
  end

endmodule

### test/tb_area_average_downscaler.sv
`timescale 1ns / 1ps
module tb_area_average_downscaler;

  logic clk;
  logic rst;
  logic src_valid;
  logic src_stall;
  aad_pkg::pix_in_t src_data;
  logic dst_valid;
  logic dst_stall;
  aad_pkg::pix_out_t dst_data;
  logic cfg_we;
  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [aad_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors, pending, results_seen;
  int pixels_sent;
  int frames_sent;
  int send_idle_pct;
  int recv_stall_pct;

  area_average_downscaler u_dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  aad_checker u_checker (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) dst_stall <= 1'b0;
    else dst_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // wait out outstanding averages and the block's tail before touching registers
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(int unsigned sc, int unsigned sr, int unsigned dc,
                           int unsigned dr, int unsigned ch);
    logic [aad_pkg::CFG_DATA_W-1:0] vals [5];
    vals[0] = aad_pkg::CFG_DATA_W'(sc);
    vals[1] = aad_pkg::CFG_DATA_W'(sr);
    vals[2] = aad_pkg::CFG_DATA_W'(dc);
    vals[3] = aad_pkg::CFG_DATA_W'(dr);
    vals[4] = aad_pkg::CFG_DATA_W'(ch);
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= aad_pkg::CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(aad_pkg::pix_in_t p);
    if (pixels_sent < 170) begin
      send_idle_pct = 32; recv_stall_pct = 68;
    end else if (pixels_sent < 340) begin
      send_idle_pct = 68; recv_stall_pct = 32;
    end else begin
      send_idle_pct = 0; recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data <= p;
    @(negedge clk);
    while (src_stall) @(negedge clk);
    @(posedge clk);
    pixels_sent++;
  endtask

  function automatic aad_pkg::pix_in_t random_pixel();
    aad_pkg::pix_in_t p;
    p = {$urandom, $urandom};
    return p;
  endfunction

  task automatic send_frames(int unsigned npix);
    for (int unsigned i = 0; i < npix; i++) send_pixel(random_pixel());
    src_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sc, sr;
    rst = 1'b1;
    src_valid = 1'b0;
    src_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixels_sent = 0;
    frames_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes, no footprint closes yet
    send_pixel('0);
    send_pixel('1);
    send_pixel(random_pixel());
    src_valid <= 1'b0;
    // zero registers clamp to a 1x1 frame
    configure(0, 0, 0, 0, 0);
    send_pixel('0);
    send_pixel('1);
    send_pixel({16'hffff, 16'h0000, 16'hffff, 16'h0000});
    send_pixel({16'h0001, 16'h8000, 16'h7fff, 16'hfffe});
    src_valid <= 1'b0;
    // oversize registers clamp to maximum width, one pixel per footprint
    configure(8191, 1, 8191, 1, 7);
    send_frames(6);
    // upscale request gets clamped
    configure(3, 2, 5, 7, 4);
    send_frames(6);
    // non-integer ratio, shared border pixels
    configure(5, 3, 2, 2, 2);
    send_pixel('1);
    send_pixel('1);
    send_pixel('1);
    send_pixel('1);
    send_pixel('1);
    send_frames(10);

    while (pixels_sent < 500) begin
      sc = $urandom_range(1, 10);
      sr = $urandom_range(1, 8);
      configure(sc, sr, $urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 7));
      if ($urandom_range(9) == 0) begin
        send_frames($urandom_range(1, sc * sr));
      end else begin
        send_frames(sc * sr * $urandom_range(1, 2));
        frames_sent++;
      end
    end

    drain();
    $display("sent %0d pixels over %0d full random frames plus clamp and ratio cases",
             pixels_sent, frames_sent);
    $display("checked %0d averaged output pixels", results_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/aad_pkg.sv
rtl/aad_ram.sv
rtl/aad_axis.sv
rtl/aad_lane.sv
rtl/area_average_downscaler.sv
test/aad_checker.sv
test/tb_area_average_downscaler.sv
